FILE: rtl/core/irn_pkg.sv
// ----------------------------------------------------------------------------
// irn_pkg
// Shared types, constants and the numeral symbol table for the Roman
// numeral encoder.
// ----------------------------------------------------------------------------
package irn_pkg;

	localparam int ValueWidth  = 12;
	localparam int LetterWidth = 7;
	localparam int NumSymbols  = 13;
	localparam int MaxValid    = 3999;

	typedef logic [ValueWidth-1:0]  value_t;
	typedef logic [LetterWidth-1:0] letter_t;
	typedef logic [3:0]             sym_idx_t;

	localparam letter_t NoLetter = 7'h00;
	localparam letter_t LetterM  = 7'h4D;
	localparam letter_t LetterD  = 7'h44;
	localparam letter_t LetterC  = 7'h43;
	localparam letter_t LetterL  = 7'h4C;
	localparam letter_t LetterX  = 7'h58;
	localparam letter_t LetterV  = 7'h56;
	localparam letter_t LetterI  = 7'h49;

	typedef enum logic [0:0] {
		IDLE_ST,
		RUN_ST
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} irn_cmd_t;

	typedef struct packed {
		logic last;
	} irn_status_t;

	// Symbols in descending weight, subtractive pairs included.
	function automatic value_t sym_weight(input sym_idx_t idx);
		case (idx)
			4'd0:    return value_t'(1000);
			4'd1:    return value_t'(900);
			4'd2:    return value_t'(500);
			4'd3:    return value_t'(400);
			4'd4:    return value_t'(100);
			4'd5:    return value_t'(90);
			4'd6:    return value_t'(50);
			4'd7:    return value_t'(40);
			4'd8:    return value_t'(10);
			4'd9:    return value_t'(9);
			4'd10:   return value_t'(5);
			4'd11:   return value_t'(4);
			default: return value_t'(1);
		endcase
	endfunction

	function automatic letter_t sym_first(input sym_idx_t idx);
		case (idx)
			4'd0:    return LetterM;
			4'd1:    return LetterC;
			4'd2:    return LetterD;
			4'd3:    return LetterC;
			4'd4:    return LetterC;
			4'd5:    return LetterX;
			4'd6:    return LetterL;
			4'd7:    return LetterX;
			4'd8:    return LetterX;
			4'd9:    return LetterI;
			4'd10:   return LetterV;
			4'd11:   return LetterI;
			default: return LetterI;
		endcase
	endfunction

	function automatic letter_t sym_second(input sym_idx_t idx);
		case (idx)
			4'd1:    return LetterM;
			4'd3:    return LetterD;
			4'd5:    return LetterC;
			4'd7:    return LetterL;
			4'd9:    return LetterX;
			4'd11:   return LetterV;
			default: return NoLetter;
		endcase
	endfunction

	// Largest symbol whose weight still fits into rest.
	function automatic sym_idx_t find_symbol(input value_t rest);
		sym_idx_t idx;
		idx = sym_idx_t'(NumSymbols - 1);
		for (int s = NumSymbols - 1; s >= 0; s--) begin
			if (rest >= sym_weight(sym_idx_t'(s))) begin
				idx = sym_idx_t'(s);
			end
		end
		return idx;
	endfunction

endpackage

FILE: rtl/core/irn_in_if.sv
// ----------------------------------------------------------------------------
// irn_in_if
// Request channel carrying one number to encode.
// ----------------------------------------------------------------------------
interface irn_in_if;
	logic                            valid;
	logic                            ready;
	logic [irn_pkg::ValueWidth-1:0]  value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

FILE: rtl/core/irn_out_if.sv
// ----------------------------------------------------------------------------
// irn_out_if
// Result channel carrying one numeral letter with its flags.
// ----------------------------------------------------------------------------
interface irn_out_if;
	logic                            valid;
	logic                            ready;
	logic [irn_pkg::LetterWidth-1:0] letter;
	logic                            last_letter;
	logic                            out_of_range;

	modport source(output valid, output letter, output last_letter, output out_of_range,
		input ready);
	modport sink(input valid, input letter, input last_letter, input out_of_range,
		output ready);
endinterface

FILE: rtl/core/integer_to_roman_numeral_unit.sv
// An accepted request starts a run; each step registers one letter, one per
// cycle while the output is not stalled. The longest numeral (3888) has 15
// letters; an out-of-range value gives one flagged letter. One request at a
// time: the next is accepted once the last letter is registered. Reset
// (arst_n low) clears the controller and output valid.
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_unit
// Encodes a 12-bit number as a run of Roman numeral letters, one per result.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_unit (
	input logic       clk,
	input logic       arst_n,
	irn_in_if.sink    in_req,
	irn_out_if.source out_req
);
	import irn_pkg::*;

	irn_cmd_t    cmd;
	irn_status_t status;

	irn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_req.valid),
		.in_ready  (in_req.ready),
		.out_valid (out_req.valid),
		.out_ready (out_req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	irn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (in_req.value),
		.letter       (out_req.letter),
		.last_letter  (out_req.last_letter),
		.out_of_range (out_req.out_of_range),
		.status       (status)
	);

endmodule

FILE: rtl/core/irn_ctrl.sv
// ----------------------------------------------------------------------------
// irn_ctrl
// Controller: takes one request at a time, steps the datapath once per
// free output slot and owns the output valid flag.
// ----------------------------------------------------------------------------
module irn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  irn_pkg::irn_status_t status,
	output irn_pkg::irn_cmd_t    cmd
);
	import irn_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE_ST;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			IDLE_ST: begin
				if (in_valid) begin
					state_d = RUN_ST;
				end
			end
			RUN_ST: begin
				if (cmd.step && status.last) begin
					state_d = IDLE_ST;
				end
			end
			default: state_d = IDLE_ST;
		endcase
	end

	always_comb begin
		in_ready = (state_q == IDLE_ST);
		cmd.load = in_valid && (state_q == IDLE_ST);
		// advance only when the output register is empty or being drained
		cmd.step = (state_q == RUN_ST) && (!out_valid_q || out_ready);
		if (cmd.step) begin
			out_valid_d = 1'b1;
		end else begin
			out_valid_d = out_valid_q && !out_ready;
		end
		out_valid = out_valid_q;
	end

`ifndef SYNTHESIS
	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == RUN_ST)
		else $error("accepted request did not start a run");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.last) |=> state_q == IDLE_ST)
		else $error("run did not end after last letter");

	a_valid_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.step))
		else $error("output valid raised without a datapath step");
`endif

endmodule

FILE: rtl/core/irn_dp.sv
// ----------------------------------------------------------------------------
// irn_dp
// Datapath: remaining value, pending second letter of a subtractive pair,
// symbol selection and the output register.
// ----------------------------------------------------------------------------
module irn_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  irn_pkg::irn_cmd_t               cmd,
	input  logic [irn_pkg::ValueWidth-1:0]  value,
	output logic [irn_pkg::LetterWidth-1:0] letter,
	output logic                            last_letter,
	output logic                            out_of_range,
	output irn_pkg::irn_status_t            status
);
	import irn_pkg::*;

	value_t   rest_q;
	sym_idx_t sym_q;
	logic     half_q;
	logic     err_q;

	letter_t  letter_q;
	logic     last_q;
	logic     oor_q;

	sym_idx_t sel;
	sym_idx_t cur;
	value_t   rest_sub;
	logic     finish;
	letter_t  letter_d;
	logic     last_d;

	always_comb begin
		sel      = find_symbol(rest_q);
		cur      = half_q ? sym_q : sel;
		rest_sub = rest_q - sym_weight(cur);
		// a symbol is done after its only letter or its second letter
		finish   = half_q || (sym_second(cur) == NoLetter);
		if (err_q) begin
			letter_d = NoLetter;
			last_d   = 1'b1;
		end else begin
			letter_d = half_q ? sym_second(cur) : sym_first(cur);
			last_d   = finish && (rest_sub == '0);
		end
		status.last = last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (cmd.load) begin
			half_q <= 1'b0;
			err_q  <= (value == '0) || (value > value_t'(MaxValid));
		end else if (cmd.step && !err_q) begin
			half_q <= !finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= value;
		end else if (cmd.step && !err_q) begin
			sym_q <= cur;
			if (finish) begin
				rest_q <= rest_sub;
			end
		end
		if (cmd.step) begin
			letter_q <= letter_d;
			last_q   <= last_d;
			oor_q    <= err_q;
		end
	end

	assign letter       = letter_q;
	assign last_letter  = last_q;
	assign out_of_range = oor_q;

`ifndef SYNTHESIS
	a_no_pair_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> !err_q)
		else $error("pair pending on an out-of-range request");

	a_rest_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !err_q && !half_q) |-> rest_q != '0)
		else $error("step with nothing left to encode");

	a_load_clears_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !half_q)
		else $error("pair pending after a new request");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Roman numeral encoder. A scoreboard works out
// the letter run of every accepted number and compares each letter that
// leaves the block with the oldest one still owed. Directed numbers cover
// the extremes, every subtractive pair and the out-of-range cases. Random
// numbers then run under three pacing schemes on both channels, with one
// long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
	import irn_pkg::*;

	typedef struct packed {
		letter_t letter;
		logic    last_letter;
		logic    out_of_range;
	} numeral_letter_t;

	class numeral_scoreboard;
		numeral_letter_t owed_q[$];
		int unsigned     errors;
		int unsigned     requests;
		int unsigned     letters;
		int unsigned     rejects;

		// Greedy symbol set, largest weight first; NoLetter marks one-letter symbols.
		int unsigned     weights[13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
		letter_t         lead[13]    = '{LetterM, LetterC, LetterD, LetterC, LetterC, LetterX,
			LetterL, LetterX, LetterX, LetterI, LetterV, LetterI, LetterI};
		letter_t         trail[13]   = '{NoLetter, LetterM, NoLetter, LetterD, NoLetter, LetterC,
			NoLetter, LetterL, NoLetter, LetterX, NoLetter, LetterV, NoLetter};

		function void note_request(input value_t number);
			numeral_letter_t run[$];
			int unsigned     rest;
			rest = 32'(number);
			requests++;
			if (rest == 0 || rest > MaxValid) begin
				rejects++;
				run.push_back('{NoLetter, 1'b1, 1'b1});
			end else begin
				for (int s = 0; s < 13; s++) begin
					while (rest >= weights[s]) begin
						run.push_back('{lead[s], 1'b0, 1'b0});
						if (trail[s] != NoLetter) begin
							run.push_back('{trail[s], 1'b0, 1'b0});
						end
						rest -= weights[s];
					end
				end
				run[run.size()-1].last_letter = 1'b1;
			end
			foreach (run[i]) begin
				owed_q.push_back(run[i]);
			end
		endfunction

		function void check_letter(input letter_t letter, input logic last_letter,
			input logic out_of_range);
			numeral_letter_t want;
			letters++;
			if (owed_q.size() == 0) begin
				$error("letter 0x%02h with no request pending", letter);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (letter !== want.letter) begin
				$error("letter: expected 0x%02h, got 0x%02h", want.letter, letter);
				errors++;
			end
			if (last_letter !== want.last_letter) begin
				$error("last_letter: expected %0b, got %0b", want.last_letter, last_letter);
				errors++;
			end
			if (out_of_range !== want.out_of_range) begin
				$error("out_of_range: expected %0b, got %0b", want.out_of_range, out_of_range);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

	localparam int unsigned CycleLimit  = 600000;
	localparam int unsigned TailCycles  = 24;
	localparam int unsigned PhaseItems  = 145;

	logic clk = 1'b0;
	logic arst_n;

	irn_in_if  in_bus();
	irn_out_if out_bus();

	numeral_scoreboard sb = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_off_req;
	int unsigned cycles;

	integer_to_roman_numeral_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_req (in_bus),
		.out_req(out_bus)
	);

	always #5 clk = ~clk;

	task automatic send_value(input value_t number);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.value <= number;
		do @(posedge clk); while (!in_bus.ready);
		sb.note_request(number);
	endtask

	task automatic wait_drained();
		in_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic value_t pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 5) return value_t'(0);
		if (roll < 12) return value_t'($urandom_range(MaxValid + 1, 4095));
		if (roll < 25) return value_t'($urandom_range(1, 60));
		return value_t'($urandom_range(1, MaxValid));
	endfunction

	task automatic run_random(input int unsigned send_pct, input int unsigned recv_pct,
		input int unsigned count);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) send_value(pick_value());
		wait_drained();
	endtask

	// Result side: check each letter that leaves, then choose next cycle's ready.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_bus.valid && out_bus.ready) begin
				sb.check_letter(out_bus.letter, out_bus.last_letter, out_bus.out_of_range);
			end
			if (hold_off_req != 0) begin
				out_bus.ready <= 1'b0;
				hold_off_req--;
			end else begin
				out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		value_t directed[$];
		directed = '{0, 1, 3999, 4000, 4095, 3888, 4, 9, 40, 90, 400, 900, 5, 50, 500,
			1000, 2, 3, 444, 1994, 2048, 1365, 2730, 4094, 3};
		cycles        = 0;
		hold_off_req  = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n        = 1'b0;
		in_bus.valid  = 1'b0;
		in_bus.value  = '0;
		out_bus.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_value(directed[i]);
		wait_drained();

		// Stall the output long enough that the block backs up into its input.
		hold_off_req = 180;
		repeat (12) send_value(value_t'($urandom_range(3000, MaxValid)));
		wait_drained();

		run_random(28, 79, PhaseItems);
		run_random(79, 28, PhaseItems);
		run_random(0, 0, PhaseItems);

		repeat (TailCycles) @(posedge clk);
		$display("Covered %0d numbers (%0d out of range), %0d letters checked, %0d errors",
			sb.requests, sb.rejects, sb.letters, sb.errors);
		$display("Pacing: both-side idling in two mixes, back-to-back, one long output stall");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
